FILE: sv/rdcd_pkg.sv
// Package: shared widths, register codes and channel expansion tables.
package rdcd_pkg;

   localparam int PIXEL_BITS     = 16;
   localparam int CH_BITS        = 8;
   localparam int SUM_BITS       = 10;
   localparam int IMG_W_BITS     = 10;
   localparam int IMG_H_BITS     = 11;
   localparam int DISC_BITS      = 10;
   localparam int GAP_BITS       = 4;
   localparam int ROW_BITS       = 10;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 11;

   localparam int MAX_WIDTH_DEFAULT = 512;
   localparam int HEIGHT_LIMIT      = 1024;

   localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = IMG_W_BITS'(466);
   localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = IMG_H_BITS'(530);
   localparam logic [DISC_BITS-1:0]  DISC_RESET   = DISC_BITS'(466);
   localparam logic [GAP_BITS-1:0]   GAP_RESET    = GAP_BITS'(2);

   localparam int RED_MAX   = 31;
   localparam int GREEN_MAX = 63;
   localparam int CH_MAX    = 255;
   localparam int RED_SHIFT = 11;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = CSR_INDEX_BITS'(0),
      CSR_IMAGE_HEIGHT = CSR_INDEX_BITS'(1),
      CSR_DISC_SIZE    = CSR_INDEX_BITS'(2),
      CSR_GAP_ROWS     = CSR_INDEX_BITS'(3)
   } csr_index_type;

   typedef logic [CH_BITS-1:0] lut5_type [RED_MAX+1];
   typedef logic [CH_BITS-1:0] lut6_type [GREEN_MAX+1];

   function automatic lut5_type exp5_build();
      lut5_type t;
      for (int i = 0; i <= RED_MAX; i++) begin
         t[i] = CH_BITS'((i * CH_MAX) / RED_MAX);
      end
      return t;
   endfunction

   function automatic lut6_type exp6_build();
      lut6_type t;
      for (int i = 0; i <= GREEN_MAX; i++) begin
         t[i] = CH_BITS'((i * CH_MAX) / GREEN_MAX);
      end
      return t;
   endfunction

   localparam lut5_type EXP5_TABLE = exp5_build();
   localparam lut6_type EXP6_TABLE = exp6_build();

endpackage

FILE: sv/rdcd_if.sv
// Interfaces: pixel request, RGB888 response and register write channels.
interface rdcd_req_if import rdcd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_word;
   logic                  frame_start;
   modport source (output valid, pixel_word, frame_start, input ready);
   modport sink   (input valid, pixel_word, frame_start, output ready);
endinterface

interface rdcd_rsp_if import rdcd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CH_BITS-1:0] red;
   logic [CH_BITS-1:0] green;
   logic [CH_BITS-1:0] blue;
   logic               frame_end;
   modport source (output valid, red, green, blue, frame_end, input ready);
   modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

interface rdcd_csr_if import rdcd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/rgb565_disc_crop_downscale.sv
// Top level: RGB565 disc crop and 2x2 box downscale to RGB888.
//
//  channel  dir  payload                              transfer
//  req_if   in   pixel_word[15:0], frame_start        valid && ready
//  rsp_if   out  red[7:0], green[7:0], blue[7:0], fe  valid && ready
//  csr_if   in   index[7:0], data[10:0]               valid && ready (always ready)
//
// One pixel per cycle unless stalled; a block's last pixel passes stages 1 to 4, then its result is registered.
// Pipeline: position/offsets, squares, crop and expand (row buffer read), sum.
// The row buffer is one RAM of MAX_WIDTH/2 entries, one read and one write port.
// Input stalls only when the pixel completing a block meets a full output register that is not taken.
// Synchronous reset clears position, pair sums and valid bits and loads register defaults; no RAM sweep.
module rgb565_disc_crop_downscale import rdcd_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   rdcd_req_if.sink    req_if,
   rdcd_rsp_if.source  rsp_if,
   rdcd_csr_if.sink    csr_if
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int HALF = MAX_WIDTH / 2;
   localparam int SW   = (HALF > 1) ? $clog2(HALF) : 1;
   localparam int EW   = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS;
   localparam int DXW  = ((CW + 1 > DISC_BITS) ? CW + 1 : DISC_BITS) + 1;
   localparam int DYW  = ROW_BITS + 2;
   localparam int SQW  = ((DXW > DYW) ? 2 * DXW : 2 * DYW) + 1;
   localparam int PW   = 3 * SUM_BITS;

   typedef struct packed {
      logic                   odd_col;
      logic                   odd_row;
      logic [SW-1:0]          slot;
      logic                   frame_end;
      logic                   crop;
      logic                   gap;
      logic [PIXEL_BITS-1:0]  color;
      logic signed [DXW-1:0]  dx;
      logic signed [DYW-1:0]  dy;
   } s1_type;

   typedef struct packed {
      logic                   odd_col;
      logic                   odd_row;
      logic [SW-1:0]          slot;
      logic                   frame_end;
      logic                   crop;
      logic                   gap;
      logic [PIXEL_BITS-1:0]  color;
      logic [2*DXW-1:0]       dx2;
      logic [2*DYW-1:0]       dy2;
   } s2_type;

   typedef struct packed {
      logic                   odd_col;
      logic                   odd_row;
      logic [SW-1:0]          slot;
      logic                   frame_end;
      logic [CH_BITS-1:0]     r;
      logic [CH_BITS-1:0]     g;
      logic [CH_BITS-1:0]     b;
   } s3_type;

   // configuration
   logic [IMG_W_BITS-1:0]  width_ff;
   logic [IMG_H_BITS-1:0]  height_ff;
   logic [DISC_BITS-1:0]   disc_ff;
   logic [GAP_BITS-1:0]    gap_ff;
   logic [2*DISC_BITS-1:0] d2_ff;

   // position and pipeline
   logic [CW-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   s1_type              s1_ff, s1_in;
   s2_type              s2_ff, s2_in;
   s3_type              s3_ff, s3_in, s4_ff;
   logic [PW-1:0]       pair_ff, pair_in;
   logic [PW-1:0]       mem_rd_ff;
   logic [PW-1:0]       row_mem [HALF];

   logic                out_valid_ff;
   logic [CH_BITS-1:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic                frame_end_ff;

   logic                adv, accept, s4_emits, mem_rd_en, mem_wr_en;
   logic [EW-1:0]       wreq, eff_w;
   logic [IMG_H_BITS-1:0] eff_h;
   logic [CW-1:0]       x_cur;
   logic [ROW_BITS-1:0] y_cur;
   logic                last_col, last_row;
   logic [DXW-2:0]      tx, dd;
   logic [DYW-2:0]      ty, ddy;
   logic                blank;
   logic [PIXEL_BITS-1:0] masked;
   logic [SUM_BITS-1:0] pr, pg, pb;

   // register writes
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         disc_ff   <= DISC_RESET;
         gap_ff    <= GAP_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_if.data[IMG_W_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_if.data[IMG_H_BITS-1:0];
            CSR_DISC_SIZE:    disc_ff   <= csr_if.data[DISC_BITS-1:0];
            CSR_GAP_ROWS:     gap_ff    <= csr_if.data[GAP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      d2_ff <= (2*DISC_BITS)'(disc_ff) * (2*DISC_BITS)'(disc_ff);
   end

   // flow control
   assign s4_emits     = s4_valid_ff && s4_ff.odd_col && s4_ff.odd_row;
   assign adv          = !(s4_emits && out_valid_ff && !rsp_if.ready);
   assign req_if.ready = adv;
   assign accept       = req_if.valid && adv;
   assign mem_rd_en    = adv && s3_valid_ff && s3_ff.odd_col && s3_ff.odd_row;
   assign mem_wr_en    = adv && s4_valid_ff && s4_ff.odd_col && !s4_ff.odd_row;

   // stage 1: position, offsets from disc center
   always_comb begin
      wreq = EW'(width_ff);
      if (wreq < EW'(2)) begin
         eff_w = EW'(2);
      end else if (wreq > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = wreq;
      end
      eff_w = eff_w & ~EW'(1);

      if (height_ff < IMG_H_BITS'(2)) begin
         eff_h = IMG_H_BITS'(2);
      end else if (height_ff > IMG_H_BITS'(HEIGHT_LIMIT)) begin
         eff_h = IMG_H_BITS'(HEIGHT_LIMIT);
      end else begin
         eff_h = height_ff;
      end
      eff_h = eff_h & ~IMG_H_BITS'(1);

      x_cur    = req_if.frame_start ? '0 : col_ff;
      y_cur    = req_if.frame_start ? '0 : row_ff;
      last_col = (EW'(x_cur) + EW'(1)) >= eff_w;
      last_row = (IMG_H_BITS'(y_cur) + IMG_H_BITS'(1)) >= eff_h;

      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : y_cur + ROW_BITS'(1);
      end else begin
         col_in = x_cur + CW'(1);
         row_in = y_cur;
      end

      tx  = (DXW-1)'({x_cur, 1'b1});
      dd  = (DXW-1)'(disc_ff);
      ty  = (DYW-1)'({y_cur, 1'b1});
      ddy = (DYW-1)'(disc_ff);

      s1_in.odd_col   = x_cur[0];
      s1_in.odd_row   = y_cur[0];
      s1_in.slot      = SW'(x_cur >> 1);
      s1_in.frame_end = last_col && last_row;
      s1_in.crop      = y_cur < disc_ff;
      s1_in.gap       = IMG_H_BITS'(y_cur) < (IMG_H_BITS'(disc_ff) + IMG_H_BITS'(gap_ff));
      s1_in.color     = {req_if.pixel_word[7:0], req_if.pixel_word[15:8]};
      s1_in.dx        = $signed({1'b0, tx}) - $signed({1'b0, dd});
      s1_in.dy        = $signed({1'b0, ty}) - $signed({1'b0, ddy});
   end

   // stage 2: squares
   always_comb begin
      s2_in.odd_col   = s1_ff.odd_col;
      s2_in.odd_row   = s1_ff.odd_row;
      s2_in.slot      = s1_ff.slot;
      s2_in.frame_end = s1_ff.frame_end;
      s2_in.crop      = s1_ff.crop;
      s2_in.gap       = s1_ff.gap;
      s2_in.color     = s1_ff.color;
      s2_in.dx2       = $unsigned((2*DXW)'(s1_ff.dx) * (2*DXW)'(s1_ff.dx));
      s2_in.dy2       = $unsigned((2*DYW)'(s1_ff.dy) * (2*DYW)'(s1_ff.dy));
   end

   // stage 3: crop decision and channel expansion
   always_comb begin
      blank  = s2_ff.crop ? ((SQW'(s2_ff.dx2) + SQW'(s2_ff.dy2)) > SQW'(d2_ff)) : s2_ff.gap;
      masked = blank ? '0 : s2_ff.color;
      s3_in.odd_col   = s2_ff.odd_col;
      s3_in.odd_row   = s2_ff.odd_row;
      s3_in.slot      = s2_ff.slot;
      s3_in.frame_end = s2_ff.frame_end;
      s3_in.r         = EXP5_TABLE[masked[PIXEL_BITS-1:RED_SHIFT]];
      s3_in.g         = EXP6_TABLE[masked[RED_SHIFT-1:5]];
      s3_in.b         = EXP5_TABLE[masked[4:0]];
   end

   // stage 4: pair and block sums
   always_comb begin
      pr = pair_ff[3*SUM_BITS-1:2*SUM_BITS] + SUM_BITS'(s4_ff.r);
      pg = pair_ff[2*SUM_BITS-1:SUM_BITS]   + SUM_BITS'(s4_ff.g);
      pb = pair_ff[SUM_BITS-1:0]            + SUM_BITS'(s4_ff.b);
      pair_in = {SUM_BITS'(s4_ff.r), SUM_BITS'(s4_ff.g), SUM_BITS'(s4_ff.b)};
      red_in   = CH_BITS'((mem_rd_ff[3*SUM_BITS-1:2*SUM_BITS] + pr) >> 2);
      green_in = CH_BITS'((mem_rd_ff[2*SUM_BITS-1:SUM_BITS] + pg) >> 2);
      blue_in  = CH_BITS'((mem_rd_ff[SUM_BITS-1:0] + pb) >> 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         pair_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (adv) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
            if (s4_valid_ff && !s4_ff.odd_col) begin
               pair_ff <= pair_in;
            end
         end
         if (adv && s4_emits) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s3_ff;
      end
      if (adv && s4_emits) begin
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         frame_end_ff <= s4_ff.frame_end;
      end
   end

   // row buffer
   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         mem_rd_ff <= row_mem[s3_ff.slot];
      end
      if (mem_wr_en) begin
         row_mem[s4_ff.slot] <= {pr, pg, pb};
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.red       = red_ff;
   assign rsp_if.green     = green_ff;
   assign rsp_if.blue      = blue_ff;
   assign rsp_if.frame_end = frame_end_ff;

   a_rd_wr_apart: assert property (@(posedge clock) disable iff (reset)
      !(mem_rd_en && mem_wr_en))
      else $error("row buffer read and write in the same cycle");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (rsp_if.valid && !rsp_if.ready && s4_emits))
      else $error("input stalled without a blocked result");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (CW+1)'(col_ff) < (CW+1)'(MAX_WIDTH))
      else $error("column position out of range");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_if.valid && !s1_valid_ff && !s4_valid_ff))
      else $error("pipeline not cleared by reset");

endmodule
